[rtl/core/assert_macros.svh]
// Assertion macros shared by the local map window RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define LMWS_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define LMWS_ASSERT_NEVER(name, clk, rstn, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[rtl/core/lmws_pkg.sv]
// Shared constants, codes and types of the local map window shift block.
`timescale 1ns / 1ps

package lmws_pkg;

  // Default coordinate width of the window corners.
  localparam int LMWS_COORD_WIDTH = 32;

  // Field widths.
  localparam int POS_W      = 32;
  localparam int LEN_W      = 24;
  localparam int RANGE_W    = 20;
  localparam int THRESH_W   = 11;
  localparam int TQ_W       = 23;
  localparam int MOV_W      = 28;
  localparam int IN_DATA_W  = 3 * POS_W;
  localparam int OUT_DATA_W = 6 * POS_W;
  localparam int OUT_USER_W = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_CUBE_LEN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DET_RANGE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESH = 2'd2;

  // Register values after reset.
  localparam logic [LEN_W-1:0]    CUBE_LEN_RST    = 24'd1000000;
  localparam logic [RANGE_W-1:0]  DET_RANGE_RST   = 20'd300000;
  localparam logic [THRESH_W-1:0] MOVE_THRESH_RST = 11'd384;

  // Cycles for the derived settings to settle after reset or a write.
  localparam int BUSY_W = 3;
  localparam logic [BUSY_W-1:0] CFG_LAT = 3'd5;

  // Result kinds.
  typedef enum logic [OUT_USER_W-1:0] {
    KIND_INIT    = 2'd0,
    KIND_NO_MOVE = 2'd1,
    KIND_BOX     = 2'd2
  } kind_e;

  // Settings handed from the configuration unit to the datapath.
  typedef struct packed {
    logic [LEN_W-1:0]        cube_len;
    logic [TQ_W-1:0]         tq;
    logic signed [MOV_W-1:0] mov;
    logic                    busy;
  } lmws_derived_t;

endpackage

[rtl/core/lmws_cfg.sv]
// Configuration registers and the pipeline that derives threshold and shift distance.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lmws_cfg import lmws_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output lmws_derived_t         derived_o
);

  // Reciprocal of five for a 34-bit shift, and the bias that keeps the quotient positive.
  localparam logic [31:0]        RECIP5_C = 32'hCCCCCCCD;
  localparam logic signed [38:0] ROUND_C  = 39'sd2560;
  localparam logic signed [38:0] BIAS_C   = 39'sd335544320;
  localparam logic signed [MOV_W-1:0] UNBIAS_C = 28'sd67108864;

  logic                 cfg_write;
  logic [LEN_W-1:0]     cube_len_q;
  logic [RANGE_W-1:0]   det_range_q;
  logic [THRESH_W-1:0]  move_thresh_q;
  logic [BUSY_W-1:0]    busy_q;

  logic [30:0]          prod_p_q;
  logic signed [32:0]   prod_b_q;
  logic [LEN_W-1:0]     len_s1_q;
  logic signed [11:0]   mt_off;
  logic signed [20:0]   dr_s;

  logic [TQ_W-1:0]      tq_q;
  logic signed [38:0]   a_q, b_q;
  logic signed [38:0]   lin_s, two_p, dif, b_x;

  logic signed [38:0]   x_sum, y_shr;
  logic [28:0]          u_q;
  logic [60:0]          recip_q;
  logic signed [MOV_W-1:0] mov_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Register file; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cube_len_q    <= CUBE_LEN_RST;
      det_range_q   <= DET_RANGE_RST;
      move_thresh_q <= MOVE_THRESH_RST;
    end else if (cfg_write) begin
      if (cfg_index_i == CFG_CUBE_LEN) begin
        cube_len_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_DET_RANGE) begin
        det_range_q <= cfg_data_i[RANGE_W-1:0];
      end else if (cfg_index_i == CFG_MOVE_THRESH) begin
        move_thresh_q <= cfg_data_i[THRESH_W-1:0];
      end
    end
  end

  // Settling counter: the datapath takes no request while it runs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= CFG_LAT;
    end else if (cfg_write) begin
      busy_q <= CFG_LAT;
    end else if (busy_q != '0) begin
      busy_q <= busy_q - 1'b1;
    end
  end

  // Stage 1: the two products of threshold factor and detection range.
  assign mt_off = $signed({1'b0, move_thresh_q}) - 12'sd256;
  assign dr_s   = $signed({1'b0, det_range_q});

  always_ff @(posedge clk_i) begin
    prod_p_q <= 31'(move_thresh_q) * 31'(det_range_q);
    prod_b_q <= 33'(mt_off) * 33'(dr_s);
    len_s1_q <= cube_len_q;
  end

  // Stage 2: near threshold and both shift candidates in units of 1/5120 mm.
  assign lin_s = $signed(39'({len_s1_q, 8'b0}));
  assign two_p = $signed(39'({prod_p_q, 1'b0}));
  assign dif   = lin_s - two_p;
  assign b_x   = 39'(prod_b_q);

  always_ff @(posedge clk_i) begin
    tq_q <= prod_p_q[30:8];
    a_q  <= (dif <<< 3) + dif;
    b_q  <= (b_x <<< 4) + (b_x <<< 2);
  end

  // Stage 3: larger candidate, rounded, divided by 1024 and biased positive.
  assign x_sum = ((a_q > b_q) ? a_q : b_q) + ROUND_C;
  assign y_shr = x_sum >>> 10;

  always_ff @(posedge clk_i) begin
    u_q <= 29'(y_shr + BIAS_C);
  end

  // Stage 4: divide by five through the reciprocal.
  always_ff @(posedge clk_i) begin
    recip_q <= 61'(u_q) * 61'(RECIP5_C);
  end

  // Stage 5: remove the bias to get the signed shift distance.
  always_ff @(posedge clk_i) begin
    mov_q <= $signed({1'b0, recip_q[60:34]}) - UNBIAS_C;
  end

  assign derived_o.cube_len = cube_len_q;
  assign derived_o.tq       = tq_q;
  assign derived_o.mov      = mov_q;
  assign derived_o.busy     = (busy_q != '0);

  `LMWS_ASSERT(a_write_sets_busy, clk_i, rst_ni, cfg_write |=> derived_o.busy, "write did not raise busy")
  `LMWS_ASSERT(a_settled_stays, clk_i, rst_ni, !derived_o.busy && !cfg_write |=> !derived_o.busy, "busy rose without a write")
  `LMWS_ASSERT(a_mov_stable, clk_i, rst_ni, !derived_o.busy && !cfg_write |=> $stable(mov_q), "shift distance moved while settled")

endmodule

[rtl/core/local_map_window_shift.sv]
// A request waits in the input register until the result register is free. One
// position per cycle while each gives one result and the output does not stall; a
// position that shifts the window on k axes holds the result register until its k
// results leave. Reset clears the window, and the input stays not ready after reset
// and after every configuration write while the five-stage shift pipeline settles.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module local_map_window_shift import lmws_pkg::*; #(
  parameter int COORD_WIDTH = LMWS_COORD_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Position requests.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
  // Results.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // box_lo_x/y/z, box_hi_x/y/z
  output logic [OUT_USER_W-1:0] m_axis_tuser,   // kind
  output logic                  m_axis_tlast,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW  = COORD_WIDTH;
  localparam int OPW = ((CW > POS_W) ? CW : POS_W) + 2;
  localparam logic signed [CW-1:0] CMAX_C = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN_C = {1'b1, {(CW-1){1'b0}}};
  localparam bit FULL64_C = (CW == 64);

  typedef struct packed {
    kind_e                   kind;
    logic [2:0][POS_W-1:0]   hi;
    logic [2:0][POS_W-1:0]   lo;
    logic                    last;
  } res_t;

  // Sign extension to the working width.
  function automatic logic signed [OPW-1:0] sx_c(input logic signed [CW-1:0] v);
    sx_c = OPW'(v);
  endfunction

  // Clamp a working-width value to the coordinate range.
  function automatic logic signed [CW-1:0] sat_c(input logic signed [OPW-1:0] s);
    if (s > sx_c(CMAX_C)) begin
      sat_c = CMAX_C;
    end else if (s < sx_c(CMIN_C)) begin
      sat_c = CMIN_C;
    end else begin
      sat_c = CW'(s);
    end
  endfunction

  function automatic logic signed [CW-1:0] csum(input logic signed [OPW-1:0] a,
                                                 input logic signed [OPW-1:0] b);
    csum = sat_c(a + b);
  endfunction

  // Low 32 bits of the sign-extended coordinate.
  function automatic logic [POS_W-1:0] to32(input logic signed [CW-1:0] v);
    logic signed [OPW-1:0] e;
    e = sx_c(v);
    to32 = e[POS_W-1:0];
  endfunction

  // Distance to a face; a full 64-bit corner at the minimum counts one closer.
  function automatic logic signed [OPW-1:0] face_dist(input logic signed [CW-1:0] p,
                                                       input logic signed [CW-1:0] w);
    logic signed [OPW-1:0] ws;
    logic signed [OPW-1:0] d;
    ws = sx_c(w);
    if (FULL64_C && (w == CMIN_C)) begin
      ws = ws + 1'b1;
    end
    d = sx_c(p) - ws;
    face_dist = d[OPW-1] ? -d : d;
  endfunction

  lmws_derived_t derived;

  logic                     in_valid_q;
  logic [POS_W-1:0]         pos_q [3];
  logic                     in_move;
  logic                     pop;

  logic                     win_ready_q;
  logic signed [CW-1:0]     win_min_q [3];
  logic signed [CW-1:0]     win_max_q [3];

  logic signed [CW-1:0]     pos_c [3];
  logic signed [CW-1:0]     init_min [3];
  logic signed [CW-1:0]     init_max [3];
  logic signed [CW-1:0]     new_min [3];
  logic signed [CW-1:0]     new_max [3];
  logic signed [OPW-1:0]    half_s, len_s, mov_s, tq_s;
  logic signed [OPW-1:0]    step [3];
  logic [2:0]               near_min, near_max, near;
  logic [1:0]               near_cnt;
  res_t                     box [3];

  res_t                     res_d [3];
  logic [1:0]               cnt_d;
  logic [1:0]               slot;
  res_t                     res_q [3];
  logic [1:0]               res_cnt_q;

  lmws_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .derived_o   (derived)
  );

  // Handshakes: the input register moves on when the result register is free
  // or hands over its last result in the same cycle.
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign in_move       = in_valid_q &&
                         ((res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && pop));
  assign s_axis_tready = !derived.busy && (!in_valid_q || in_move);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (in_move) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pos_q[0] <= s_axis_tdata[POS_W-1:0];
      pos_q[1] <= s_axis_tdata[2*POS_W-1:POS_W];
      pos_q[2] <= s_axis_tdata[3*POS_W-1:2*POS_W];
    end
  end

  // Settings widened to the working width.
  assign half_s = $signed(OPW'(derived.cube_len >> 1));
  assign len_s  = $signed(OPW'(derived.cube_len));
  assign mov_s  = OPW'(derived.mov);
  assign tq_s   = $signed(OPW'(derived.tq));

  // Per-axis face tests, initial window and shifted window.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_c[i]    = sat_c(OPW'($signed(pos_q[i])));
      init_min[i] = csum(sx_c(pos_c[i]), -half_s);
      init_max[i] = csum(sx_c(init_min[i]), len_s);
      near_min[i] = face_dist(pos_c[i], win_min_q[i]) <= tq_s;
      near_max[i] = face_dist(pos_c[i], win_max_q[i]) <= tq_s;
      near[i]     = near_min[i] || near_max[i];
      step[i]     = near_min[i] ? -mov_s : mov_s;
      new_min[i]  = csum(sx_c(win_min_q[i]), step[i]);
      new_max[i]  = csum(sx_c(win_max_q[i]), step[i]);
    end
  end

  assign near_cnt = 2'($countones(near));

  // Removal box per axis: the old window with the slid-out slab on that axis.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      box[i].kind = KIND_BOX;
      box[i].last = 1'b0;
      for (int j = 0; j < 3; j++) begin
        box[i].lo[j] = to32(win_min_q[j]);
        box[i].hi[j] = to32(win_max_q[j]);
      end
      if (near_min[i]) begin
        box[i].lo[i] = to32(new_max[i]);
      end else begin
        box[i].hi[i] = to32(new_min[i]);
      end
    end
  end

  // Results of the item in the input register, packed in axis order.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res_d[k] = '0;
    end
    slot  = 2'd0;
    cnt_d = 2'd1;
    if (!win_ready_q) begin
      res_d[0].kind = KIND_INIT;
      res_d[0].last = 1'b1;
    end else if (near == 3'b000) begin
      res_d[0].kind = KIND_NO_MOVE;
      res_d[0].last = 1'b1;
    end else begin
      cnt_d = near_cnt;
      for (int i = 0; i < 3; i++) begin
        if (near[i]) begin
          res_d[slot]      = box[i];
          res_d[slot].last = (slot == near_cnt - 2'd1);
          slot             = slot + 2'd1;
        end
      end
    end
  end

  // Window state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_ready_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        win_min_q[i] <= '0;
        win_max_q[i] <= '0;
      end
    end else if (in_move) begin
      win_ready_q <= 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (!win_ready_q) begin
          win_min_q[i] <= init_min[i];
          win_max_q[i] <= init_max[i];
        end else if (near[i]) begin
          win_min_q[i] <= new_min[i];
          win_max_q[i] <= new_max[i];
        end
      end
    end
  end

  // Result register: up to three results leave in order, the front one shown.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= 2'd0;
    end else if (in_move) begin
      res_cnt_q <= cnt_d;
    end else if (pop) begin
      res_cnt_q <= res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_move) begin
      res_q <= res_d;
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

  assign m_axis_tvalid = (res_cnt_q != 2'd0);
  assign m_axis_tdata  = {res_q[0].hi, res_q[0].lo};
  assign m_axis_tuser  = res_q[0].kind;
  assign m_axis_tlast  = res_q[0].last;

  `LMWS_ASSERT(a_last_matches_count, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tlast == (res_cnt_q == 2'd1)), "tlast disagrees with pending count")
  `LMWS_ASSERT(a_plain_is_single, clk_i, rst_ni, m_axis_tvalid && (res_q[0].kind != KIND_BOX) |-> m_axis_tlast, "plain result not alone")
  `LMWS_ASSERT_NEVER(a_accept_while_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && derived.busy, "request taken while settings settle")
  `LMWS_ASSERT(a_window_set, clk_i, rst_ni, in_move |=> win_ready_q, "window not marked set after an item")

endmodule
